// File: rtl/iir_df1_pkg.sv
`default_nettype none

package iir_df1_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned COEF_SCALE = 10000;

  // The divider only needs enough quotient bits to tell saturation apart.
  localparam int unsigned QUOT_W = 17;
  localparam int unsigned REM_W  = 31;

  localparam logic [ACC_W-1:0] MAG_LIMIT = ACC_W'(COEF_SCALE) << QUOT_W;

  // Division by 10000 is a shift by four followed by a multiply with the
  // rounded-up reciprocal of 625, exact for every dividend below 2**DIVD_W.
  localparam int unsigned PRE_SHIFT   = 4;
  localparam int unsigned DIVD_W      = REM_W - PRE_SHIFT;
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned PROD_W      = DIVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(219902326);

  localparam logic [CNT_W-1:0]      NUM_COUNT_RST     = CNT_W'(1);
  localparam logic [CNT_W-1:0]      DEN_COUNT_RST     = CNT_W'(0);
  localparam logic [CFG_DATA_W-1:0] NUM_COEFS_LOW_RST = CFG_DATA_W'(COEF_SCALE);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    out_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COUNT      = 3'd0,
    CFG_DEN_COUNT      = 3'd1,
    CFG_NUM_COEFS_LOW  = 3'd2,
    CFG_NUM_COEFS_HIGH = 3'd3,
    CFG_DEN_COEFS_LOW  = 3'd4,
    CFG_DEN_COEFS_HIGH = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAIN,
    ST_DIV
  } state_e;

  // Control broadcast from the sequencer to every tap cell.
  typedef struct packed {
    logic load;
    logic shift;
    cnt_t num_cnt;
    cnt_t den_cnt;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/iir_df1_if.sv
`default_nettype none

interface iir_df1_sample_if;
  logic                  valid;
  logic                  ready;
  iir_df1_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface iir_df1_result_if;
  logic               valid;
  logic               ready;
  iir_df1_pkg::out_t  filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

interface iir_df1_cfg_if;
  logic                   valid;
  logic                   ready;
  iir_df1_pkg::cfg_idx_t  index;
  iir_df1_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/iir_df1_cell.sv
`default_nettype none

module iir_df1_cell #(
  parameter int unsigned IDX   = 0,
  parameter bit          HAS_X = 1'b1,
  parameter bit          HAS_Y = 1'b1
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  iir_df1_pkg::cell_ctrl_t  ctrl_i,
  input  wire                      tok_i,
  input  iir_df1_pkg::acc_t        psum_i,
  input  iir_df1_pkg::sample_t     x_i,
  input  iir_df1_pkg::out_t        y_i,
  input  iir_df1_pkg::coef_t       b_i,
  input  iir_df1_pkg::coef_t       a_i,
  output logic                     tok_o,
  output iir_df1_pkg::acc_t        psum_o,
  output iir_df1_pkg::sample_t     x_o,
  output iir_df1_pkg::out_t        y_o
);
  import iir_df1_pkg::*;

  localparam cnt_t MY_IDX = CNT_W'(IDX);

  acc_t term_x, term_y;
  logic tok_q;
  acc_t psum_q;

  generate
    if (HAS_X) begin : g_x
      sample_t x_q;
      logic signed [SAMPLE_W+COEF_W-1:0] prod_x;

      assign prod_x = x_q * b_i;
      assign term_x = (MY_IDX < ctrl_i.num_cnt)
                    ? {{(ACC_W-SAMPLE_W-COEF_W){prod_x[SAMPLE_W+COEF_W-1]}}, prod_x}
                    : '0;
      assign x_o = x_q;

      // Tap zero always holds the newest sample; the older taps move along
      // only across the span of taps in use.
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          x_q <= '0;
        end else if (IDX == 0) begin
          if (ctrl_i.load) begin
            x_q <= x_i;
          end
        end else if (ctrl_i.shift && (MY_IDX < ctrl_i.num_cnt)) begin
          x_q <= x_i;
        end
      end
    end else begin : g_no_x
      assign term_x = '0;
      assign x_o    = '0;
    end

    if (HAS_Y) begin : g_y
      out_t y_q;
      logic signed [OUT_W+COEF_W-1:0] prod_y;

      assign prod_y = y_q * a_i;
      assign term_y = (MY_IDX < ctrl_i.den_cnt)
                    ? {{(ACC_W-OUT_W-COEF_W){prod_y[OUT_W+COEF_W-1]}}, prod_y}
                    : '0;
      assign y_o = y_q;

      // Tap zero takes every new output, even with no feedback taps in use.
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          y_q <= '0;
        end else if (ctrl_i.shift && ((IDX == 0) || (MY_IDX < ctrl_i.den_cnt))) begin
          y_q <= y_i;
        end
      end
    end else begin : g_no_y
      assign term_y = '0;
      assign y_o    = '0;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      psum_q <= psum_i + term_x - term_y;
    end
  end

  assign tok_o  = tok_q;
  assign psum_o = psum_q;

endmodule

`default_nettype wire

// File: rtl/iir_df1_div.sv
`default_nettype none

module iir_df1_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  iir_df1_pkg::acc_t   acc_i,
  output logic                valid_o,
  output iir_df1_pkg::out_t   quot_o
);
  import iir_df1_pkg::*;

  localparam logic [QUOT_W-1:0] POS_MAX = QUOT_W'(2**(OUT_W-1) - 1);
  localparam logic [QUOT_W-1:0] NEG_MAX = QUOT_W'(2**(OUT_W-1));

  logic              neg_q, neg_d;
  logic [DIVD_W-1:0] divd_q, divd_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              mul_q, mul_d;
  logic              valid_q, valid_d;
  logic [ACC_W-1:0]  mag;
  logic [REM_W-1:0]  mag_pin;
  logic [QUOT_W-1:0] qm;
  logic [QUOT_W-1:0] qm_neg;

  assign mag     = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
  assign mag_pin = (mag >= MAG_LIMIT) ? REM_W'(MAG_LIMIT - 1'b1) : mag[REM_W-1:0];
  assign qm      = prod_q[RECIP_SHIFT +: QUOT_W];
  assign qm_neg  = ~qm + 1'b1;

  // Two steps: the magnitude is taken, pinned just below MAG_LIMIT and divided
  // by 16, then multiplied by the reciprocal of 625. The quotient is the top of
  // the product and stays until the next start.
  always_comb begin
    neg_d   = neg_q;
    divd_d  = divd_q;
    prod_d  = prod_q;
    mul_d   = start_i;
    valid_d = valid_q;
    if (start_i) begin
      neg_d   = acc_i[ACC_W-1];
      divd_d  = mag_pin[REM_W-1:PRE_SHIFT];
      valid_d = 1'b0;
    end else if (mul_q) begin
      prod_d  = PROD_W'(divd_q) * PROD_W'(RECIP);
      valid_d = 1'b1;
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (qm > NEG_MAX) ? out_t'(NEG_MAX[OUT_W-1:0]) : out_t'(qm_neg[OUT_W-1:0]);
    end else begin
      quot_o = (qm > POS_MAX) ? out_t'(POS_MAX[OUT_W-1:0]) : out_t'(qm[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      mul_q   <= mul_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    divd_q <= divd_d;
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: rtl/iir_filter_direct_form_one_core.sv
// Direct form I IIR filter in fixed point. Each signed 12-bit sample word on
// sample_i produces exactly one signed 16-bit word on result_o: the sum of the
// newest num_count input samples times the numerator coefficients, minus the
// newest den_count outputs times the denominator coefficients, divided by
// 10000 with truncation toward zero and saturated to 16 bits. Coefficients are
// signed 16-bit values scaled by 10000, packed four to a 64-bit register with
// the lowest tap in bits 15:0. Tap counts above NUM_TAPS or DEN_TAPS act as the
// limit, and a den_count of zero gives an FIR filter. Samples are handled one
// at a time: a word passes a row of max(NUM_TAPS, DEN_TAPS) tap cells, one
// cell per cycle, and then a reciprocal divider, so sample_i takes a new word
// only once the quotient of the previous one has moved to the output register,
// which waits until the result before it has left. Configuration writes are
// always taken and must only be issued while the filter is idle.
`default_nettype none

module iir_filter_direct_form_one_core #(
  parameter int unsigned NUM_TAPS = 8,
  parameter int unsigned DEN_TAPS = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  iir_df1_sample_if.sink    sample_i,
  iir_df1_result_if.source  result_o,
  iir_df1_cfg_if.sink       cfg_i
);
  import iir_df1_pkg::*;

  // The cell row is as long as the longer of the two histories.
  localparam int unsigned CHAIN_LEN = (NUM_TAPS > DEN_TAPS) ? NUM_TAPS : DEN_TAPS;

  // Configuration registers.
  cnt_t      num_count_q, den_count_q;
  cfg_data_t num_lo_q, num_hi_q, den_lo_q, den_hi_q;
  logic [2*CFG_DATA_W-1:0] num_all, den_all;

  cnt_t num_cnt, den_cnt;

  // Sequencer.
  state_e state_q, state_d;
  logic   in_acc, start_q, take;
  cell_ctrl_t ctrl;

  // Links between neighboring cells; entry 0 feeds the first cell.
  logic    tok_w  [CHAIN_LEN+1];
  acc_t    psum_w [CHAIN_LEN+1];
  sample_t x_w    [CHAIN_LEN+1];
  out_t    y_w    [CHAIN_LEN+1];

  logic div_valid;
  out_t div_quot;

  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes to an index past the register list are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_count_q <= NUM_COUNT_RST;
      den_count_q <= DEN_COUNT_RST;
      num_lo_q    <= NUM_COEFS_LOW_RST;
      num_hi_q    <= '0;
      den_lo_q    <= '0;
      den_hi_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_NUM_COUNT:      num_count_q <= cfg_i.data[CNT_W-1:0];
        CFG_DEN_COUNT:      den_count_q <= cfg_i.data[CNT_W-1:0];
        CFG_NUM_COEFS_LOW:  num_lo_q    <= cfg_i.data;
        CFG_NUM_COEFS_HIGH: num_hi_q    <= cfg_i.data;
        CFG_DEN_COEFS_LOW:  den_lo_q    <= cfg_i.data;
        CFG_DEN_COEFS_HIGH: den_hi_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign num_all = {num_hi_q, num_lo_q};
  assign den_all = {den_hi_q, den_lo_q};

  // Tap counts beyond the built history depth act as the full depth.
  assign num_cnt = (num_count_q > CNT_W'(NUM_TAPS)) ? CNT_W'(NUM_TAPS) : num_count_q;
  assign den_cnt = (den_count_q > CNT_W'(DEN_TAPS)) ? CNT_W'(DEN_TAPS) : den_count_q;

  // ---------------------------------------------------------------------------
  // Sequencer: idle, partial sum walking the cell row, then the divide. The
  // histories shift in the same cycle the quotient moves to the output
  // register, which can only happen once that register is free.
  // ---------------------------------------------------------------------------
  assign in_acc = sample_i.valid && sample_i.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc)             state_d = ST_CHAIN;
      ST_CHAIN: if (tok_w[CHAIN_LEN])   state_d = ST_DIV;
      ST_DIV:   if (take)               state_d = ST_IDLE;
      default:                          state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready = (state_q == ST_IDLE);
    take           = (state_q == ST_DIV) && div_valid && (!out_valid_q || result_o.ready);
    ctrl.load      = in_acc;
    ctrl.shift     = take;
    ctrl.num_cnt   = num_cnt;
    ctrl.den_cnt   = den_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc;
    end
  end

  // ---------------------------------------------------------------------------
  // Tap cell row. Cell i holds input history entry i and output history entry
  // i; the partial sum enters cell zero at zero and picks up one tap per cycle.
  // ---------------------------------------------------------------------------
  assign tok_w[0]  = start_q;
  assign psum_w[0] = '0;
  assign x_w[0]    = sample_i.sample;
  assign y_w[0]    = div_quot;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    localparam bit HAS_X = (i < NUM_TAPS);
    localparam bit HAS_Y = (i < DEN_TAPS);

    coef_t b_c, a_c;

    assign b_c = HAS_X ? coef_t'(num_all[COEF_W*i +: COEF_W]) : '0;
    assign a_c = HAS_Y ? coef_t'(den_all[COEF_W*i +: COEF_W]) : '0;

    iir_df1_cell #(
      .IDX   (i),
      .HAS_X (HAS_X),
      .HAS_Y (HAS_Y)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .tok_i  (tok_w[i]),
      .psum_i (psum_w[i]),
      .x_i    (x_w[i]),
      .y_i    (y_w[i]),
      .b_i    (b_c),
      .a_i    (a_c),
      .tok_o  (tok_w[i+1]),
      .psum_o (psum_w[i+1]),
      .x_o    (x_w[i+1]),
      .y_o    (y_w[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Scale-down by 10000 with truncation and saturation.
  // ---------------------------------------------------------------------------
  iir_df1_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tok_w[CHAIN_LEN]),
    .acc_i   (psum_w[CHAIN_LEN]),
    .valid_o (div_valid),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Output register. It keeps a finished word while the next sample is taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= div_quot;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.filtered = out_data_q;

endmodule

`default_nettype wire

// File: rtl/iir_df1_checker.sv
`default_nettype none

module iir_df1_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input iir_df1_pkg::out_t   out_data,
  input wire                 cfg_valid,
  input wire                 cfg_ready
);
  import iir_df1_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Only one sample is in flight: input stays closed for a while after a word.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready ##1 !in_ready)
    else $error("input reopened right after a sample was taken");

  // A new result never appears right after a sample has been taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
    else $error("result appeared too soon after a sample");

  // Register writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind iir_filter_direct_form_one_core iir_df1_checker u_iir_df1_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_data  (result_o.filtered),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

`default_nettype wire

// File: tb/iir_filter_direct_form_one_checker.sv
`default_nettype none

module iir_filter_direct_form_one_checker
  import iir_df1_pkg::*;
#(
  parameter int unsigned NUM_TAPS = 8,
  parameter int unsigned DEN_TAPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iir_df1_sample_if   sample_i,
  iir_df1_result_if   result_i,
  iir_df1_cfg_if      cfg_i,
  output int unsigned pending_o,
  output int unsigned fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cnt_t      num_cnt;
  cnt_t      den_cnt;
  cfg_data_t num_lo;
  cfg_data_t num_hi;
  cfg_data_t den_lo;
  cfg_data_t den_hi;
  sample_t   x_hist [NUM_TAPS];
  out_t      y_hist [DEN_TAPS];
  out_t      filtered_q [$];
  out_t      want;

  function automatic coef_t tap_coef(cfg_data_t lo, cfg_data_t hi, int k);
    cfg_data_t w;
    w = (k < 4) ? lo : hi;
    return coef_t'(w[16*(k%4) +: 16]);
  endfunction

  // Advances the filter by one sample word and returns the filtered word.
  function automatic out_t filter_step(sample_t s);
    longint acc;
    longint q;
    int     nn;
    int     nd;
    acc = 0;
    nn  = (num_cnt > NUM_TAPS) ? NUM_TAPS : int'(num_cnt);
    nd  = (den_cnt > DEN_TAPS) ? DEN_TAPS : int'(den_cnt);
    x_hist[0] = s;
    for (int i = 0; i < nn; i++)
      acc += longint'(x_hist[i]) * longint'(tap_coef(num_lo, num_hi, i));
    for (int i = 0; i < nd; i++)
      acc -= longint'(y_hist[i]) * longint'(tap_coef(den_lo, den_hi, i));
    q = acc / longint'(COEF_SCALE);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    for (int i = nn - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    for (int i = nd - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = out_t'(q);
    return out_t'(q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cnt = NUM_COUNT_RST;
      den_cnt = DEN_COUNT_RST;
      num_lo  = NUM_COEFS_LOW_RST;
      num_hi  = '0;
      den_lo  = '0;
      den_hi  = '0;
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      filtered_q.delete();
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      // Writes only come while the filter is idle, so they never overlap a sample.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_NUM_COUNT:      num_cnt = cfg_i.data[CNT_W-1:0];
          CFG_DEN_COUNT:      den_cnt = cfg_i.data[CNT_W-1:0];
          CFG_NUM_COEFS_LOW:  num_lo  = cfg_i.data;
          CFG_NUM_COEFS_HIGH: num_hi  = cfg_i.data;
          CFG_DEN_COEFS_LOW:  den_lo  = cfg_i.data;
          CFG_DEN_COEFS_HIGH: den_hi  = cfg_i.data;
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready)
        filtered_q.push_back(filter_step(sample_i.sample));
      if (result_i.valid && result_i.ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result word: filtered=%0d", result_i.filtered);
          fails_o <= fails_o + 1;
        end else begin
          want = filtered_q.pop_front();
          if (result_i.filtered !== want) begin
            $error("filtered mismatch: expected %0d, actual %0d", want, result_i.filtered);
            fails_o <= fails_o + 1;
          end
        end
      end
      pending_o <= filtered_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/iir_filter_direct_form_one_core_tb.sv
`default_nettype none

// Stimulus side of the filter bench. The checker beside the block predicts
// every filtered word; this module only feeds sample words and register writes
// and turns the checker's failure count into the final verdict.
module iir_filter_direct_form_one_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iir_df1_pkg::*;

  localparam int unsigned NUM_TAPS      = 8;
  localparam int unsigned DEN_TAPS      = 8;
  localparam int unsigned RAND_ITEMS    = 1600;
  localparam int unsigned IDLE_PCT      = 13;
  // Ample quiet time for one sample to pass the eight-tap row and the divider.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // Indexes past the register list; writes to them must be dropped.
  localparam cfg_idx_t CFG_UNMAPPED_A = 3'd6;
  localparam cfg_idx_t CFG_UNMAPPED_B = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  bit          steady;
  int unsigned pending;
  int unsigned fails;
  int unsigned cycle_count;
  int unsigned sent;
  int unsigned len;
  int unsigned hold;

  iir_df1_sample_if smp_if ();
  iir_df1_result_if res_if ();
  iir_df1_cfg_if    cfg_if ();

  iir_filter_direct_form_one_core #(
    .NUM_TAPS (NUM_TAPS),
    .DEN_TAPS (DEN_TAPS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  iir_filter_direct_form_one_checker #(
    .NUM_TAPS (NUM_TAPS),
    .DEN_TAPS (DEN_TAPS)
  ) checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (smp_if),
    .result_i  (res_if),
    .cfg_i     (cfg_if),
    .pending_o (pending),
    .fails_o   (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiving side stalls at random, except during the steady stretch.
  always @(posedge clk_i) begin
    res_if.ready <= rst_ni && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Packs four coefficients, each drawn from [lo, hi], into one register word.
  function automatic cfg_data_t pack_coefs(int lo, int hi);
    cfg_data_t w;
    for (int k = 0; k < 4; k++)
      w[16*k +: 16] = 16'(lo + int'($urandom_range(hi - lo)));
    return w;
  endfunction

  // Mostly uniform samples, with the two rails showing up now and then.
  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return sample_t'(2047);
      1:       return sample_t'(-2048);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offers one sample word, possibly after a random gap, and returns at the
  // edge where it is taken. Valid stays high so the next word can follow
  // back to back; whoever is done with the channel lowers it.
  task automatic send_sample(sample_t s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Rewrites every register. With spare set, junk goes to the unmapped
  // indexes first, so any effect it had would show up in the next words.
  task automatic write_regs(cfg_data_t nc, cfg_data_t dc, cfg_data_t blo,
                            cfg_data_t bhi, cfg_data_t alo, cfg_data_t ahi,
                            bit spare);
    if (spare) begin
      cfg_write(CFG_UNMAPPED_A, {$urandom, $urandom});
      cfg_write(CFG_UNMAPPED_B, {$urandom, $urandom});
    end
    cfg_write(CFG_NUM_COUNT, nc);
    cfg_write(CFG_DEN_COUNT, dc);
    cfg_write(CFG_NUM_COEFS_LOW, blo);
    cfg_write(CFG_NUM_COEFS_HIGH, bhi);
    cfg_write(CFG_DEN_COEFS_LOW, alo);
    cfg_write(CFG_DEN_COEFS_HIGH, ahi);
    cfg_if.valid <= 1'b0;
  endtask

  // Holds the sender off until every expected word is back and the block
  // has had time to fall idle. The first wait lets the checker's count
  // catch up with a word taken on the current edge.
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    steady        = 1'b0;
    sent          = 0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_NUM_COUNT;
    cfg_if.data   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset settings make a single unity tap, so samples pass straight
    // through, rails included.
    send_sample(sample_t'(2047));
    send_sample(sample_t'(-2048));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    drain_results();

    // Eight full-scale taps with no feedback: four words at each rail keep the sum
    // inside the 16-bit output range, so no clipping occurs.
    write_regs(cfg_data_t'(8), cfg_data_t'(0), pack_coefs(32767, 32767),
               pack_coefs(32767, 32767), '0, '0, 1'b1);
    repeat (4) send_sample(sample_t'(2047));
    repeat (4) send_sample(sample_t'(-2048));
    drain_results();

    // No numerator taps, so only feedback drives the output, and a
    // denominator count past the limit that must act as eight taps.
    write_regs(cfg_data_t'(0), cfg_data_t'(15), pack_coefs(32767, 32767),
               pack_coefs(-32768, -32768), pack_coefs(-32768, -32768),
               pack_coefs(-32768, -32768), 1'b0);
    repeat (5) send_sample(rand_sample());
    drain_results();

    // Numerator count past the limit with most-negative taps, one feedback tap.
    write_regs(cfg_data_t'(15), cfg_data_t'(1), pack_coefs(-32768, -32768),
               pack_coefs(-32768, -32768), pack_coefs(32767, 32767), '0, 1'b1);
    repeat (5) send_sample(rand_sample());
    drain_results();

    // Random phases cycle through three kinds of setting: a gentle filter
    // that keeps outputs in range, fully random registers (counts with
    // junk in the upper bits), and coefficient rails with edge counts.
    for (int phase = 0; sent < RAND_ITEMS; phase++) begin
      steady <= (phase == 4 || phase == 5);
      case (phase % 3)
        0: write_regs(cfg_data_t'($urandom_range(8)), cfg_data_t'($urandom_range(8)),
                      pack_coefs(-3000, 3000), pack_coefs(-3000, 3000),
                      pack_coefs(-1000, 1000), pack_coefs(-1000, 1000),
                      1'b0);
        1: write_regs({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom},
                      1'($urandom_range(1)));
        default: write_regs(cfg_data_t'($urandom_range(1) ? 8 : 15),
                            cfg_data_t'($urandom_range(2) * 4),
                            pack_coefs(-32768, 32767), pack_coefs(-32768, -32768),
                            pack_coefs(32767, 32767), pack_coefs(-32768, 32767),
                            1'b0);
      endcase
      len  = 60 + $urandom_range(80);
      hold = $urandom_range(len - 1);
      for (int k = 0; k < len; k++) begin
        // Somewhere in each phase the sender stops until the block is empty.
        if (k == hold) drain_results();
        send_sample(rand_sample());
        sent++;
      end
      drain_results();
    end

    if (fails == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/iir_df1_pkg.sv
rtl/iir_df1_if.sv
rtl/iir_df1_cell.sv
rtl/iir_df1_div.sv
rtl/iir_filter_direct_form_one_core.sv
rtl/iir_df1_checker.sv
tb/iir_filter_direct_form_one_checker.sv
tb/iir_filter_direct_form_one_core_tb.sv
